### sv/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types and codes for the text mode terminal.
// ----------------------------------------------------------------------------
package tmt_pkg;

  typedef logic [1:0]  op_t;
  typedef logic [7:0]  char_t;
  typedef logic [10:0] idx_t;
  typedef logic [10:0] pos_t;
  typedef logic [15:0] cell_t;
  typedef logic [3:0]  color_t;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam op_t OP_PUT   = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam char_t CH_BS    = 8'h08;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_BLANK = 8'h20;

  localparam int TAB_STEP = 8;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam color_t FG_RESET = 4'hF;
  localparam color_t BG_RESET = 4'h0;

endpackage

### sv/tmt_in_if.sv
// ----------------------------------------------------------------------------
// tmt_in_if
// Command channel: operation, character and cell address.
// ----------------------------------------------------------------------------
interface tmt_in_if;
  logic             valid;
  logic             ready;
  tmt_pkg::op_t     operation;
  tmt_pkg::char_t   char_code;
  tmt_pkg::idx_t    cell_index;

  modport source (output valid, output operation, output char_code,
                  output cell_index, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input cell_index, output ready);
endinterface

// ----------------------------------------------------------------------------
// tmt_out_if
// Result channel: cursor position and cell contents.
// ----------------------------------------------------------------------------
interface tmt_out_if;
  logic             valid;
  logic             ready;
  tmt_pkg::pos_t    cursor_position;
  tmt_pkg::cell_t   cell_value;

  modport source (output valid, output cursor_position, output cell_value,
                  input ready);
  modport sink   (input valid, input cursor_position, input cell_value,
                  output ready);
endinterface

### sv/text_mode_terminal_top.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_top
// Character terminal over a COLUMNS x ROWS store of 16-bit cells.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        operation, char_code, cell_index
//  out_ch   out  valid/ready        cursor_position, cell_value
//  cfg      in   APB psel/penable   foreground (0x0), background (0x4)
//
//  Put and clear results are registered at acceptance; a read result goes
//  through the registered RAM read port and the READ state. A new item is
//  taken once the sweep engine is idle and the output register is free.
//  Scroll sweeps the store through the single RAM read/write port pair.
//  Clear sweeps every cell. After reset a zeroing pass over every cell
//  runs before the first item; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_mode_terminal_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tmt_in_if.sink                         in_ch,
  tmt_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tmt_pkg::CFG_AW-1:0]     paddr,
  input  logic [tmt_pkg::CFG_DW-1:0]     pwdata,
  output logic [tmt_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);

  import tmt_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int IW     = (AW > 11) ? AW : 11;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  cell_t            fill_val_r, fill_val_nxt;
  logic             cp_pend_r;
  logic [AW-1:0]    cp_addr_r;
  logic             idx_ok_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  color_t           fg_r, bg_r;
  logic             out_valid_r, out_valid_nxt;
  pos_t             out_pos_r, out_pos_nxt;
  cell_t            out_cell_r, out_cell_nxt;

  logic             accept;
  logic             cfg_wr;
  cell_t            blank;
  cell_t            rdata;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  cell_t            wdata;

  // put decode
  logic [COL_W:0]   pc_col;
  logic [ROW_W-1:0] pc_row;
  logic             pc_we;
  logic             pc_scroll;
  logic [AW-1:0]    cur_addr;
  logic [IW-1:0]    idx_w;
  logic             idx_ok;
  logic [IW-1:0]    pos_w;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign blank  = {bg_r, fg_r, CH_BLANK};

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.cell_value      = out_cell_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FG) begin
        fg_r <= pwdata[3:0];
      end else begin
        bg_r <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FG) begin
      prdata[3:0] = fg_r;
    end else begin
      prdata[3:0] = bg_r;
    end
  end

  assign cur_addr = AW'(row_r * COLUMNS + col_r);
  assign idx_w    = IW'(in_ch.cell_index);
  assign idx_ok   = idx_w < IW'(CELLS);

  // cursor update for one put item
  always_comb begin
    pc_col    = {1'b0, col_r};
    pc_row    = row_r;
    pc_we     = 1'b0;
    pc_scroll = 1'b0;
    case (in_ch.char_code)
      CH_BS: begin
        if (col_r != '0) begin
          pc_col = {1'b0, col_r} - 1'b1;
        end
      end
      CH_TAB: begin
        pc_col = ({1'b0, col_r} + (COL_W+1)'(TAB_STEP))
                 & ~(COL_W+1)'(TAB_STEP - 1);
      end
      CH_CR: begin
        pc_col = '0;
      end
      CH_LF: begin
        pc_col = '0;
        pc_row = row_r + 1'b1;
      end
      default: begin
        if (in_ch.char_code >= CH_BLANK) begin
          pc_we  = 1'b1;
          pc_col = {1'b0, col_r} + 1'b1;
        end
      end
    endcase
    if (pc_col >= (COL_W+1)'(COLUMNS)) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end
    if (pc_row >= ROW_W'(ROWS)) begin
      pc_scroll = 1'b1;
      pc_row    = ROW_W'(ROWS - 1);
      pc_col    = '0;
    end
  end

  assign pos_w = IW'(row_nxt * COLUMNS + col_nxt);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_val_nxt  = fill_val_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_cell_nxt  = out_cell_r;
    we            = 1'b0;
    waddr         = cur_addr;
    wdata         = {bg_r, fg_r, in_ch.char_code};
    raddr         = idx_w[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            OP_PUT: begin
              we      = pc_we;
              col_nxt = pc_col[COL_W-1:0];
              row_nxt = pc_row;
              if (pc_scroll) begin
                state_nxt = ST_COPY;
                cnt_nxt   = '0;
              end
            end
            OP_CLEAR: begin
              col_nxt      = '0;
              row_nxt      = '0;
              state_nxt    = ST_FILL;
              cnt_nxt      = '0;
              fill_val_nxt = blank;
            end
            OP_READ: begin
              state_nxt = ST_READ;
            end
            default: ;
          endcase
          out_pos_nxt  = pos_w[10:0];
          out_cell_nxt = '0;
          if (in_ch.operation != OP_READ) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = idx_ok_r ? rdata : '0;
        state_nxt     = ST_IDLE;
      end
      ST_COPY: begin
        // read one row ahead, write back the cell read last cycle
        raddr = AW'(cnt_r + COLUMNS);
        if (cnt_r == AW'(COPY_N - 1)) begin
          state_nxt    = ST_FILL;
          cnt_nxt      = AW'(COPY_N);
          fill_val_nxt = blank;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        if (!cp_pend_r) begin
          we    = 1'b1;
          waddr = cnt_r;
          wdata = fill_val_r;
          if (cnt_r == AW'(CELLS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (cp_pend_r) begin
      we    = 1'b1;
      waddr = cp_addr_r;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      fill_val_r  <= '0;
      cp_pend_r   <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      cp_pend_r   <= (state_r == ST_COPY);
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r  <= cnt_r;
    out_pos_r  <= out_pos_nxt;
    out_cell_r <= out_cell_nxt;
    if (accept) begin
      idx_ok_r <= idx_ok;
    end
  end

  tmt_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

### sv/tmt_ram.sv
// ----------------------------------------------------------------------------
// tmt_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
